// File: rtl/grid_level_accumulate_clear_defines.svh
// assertion macros for the grid level accumulator checker
// no dependencies; taken in by the checker file with `include
`ifndef GRID_LEVEL_ACCUMULATE_CLEAR_DEFINES_SVH
`define GRID_LEVEL_ACCUMULATE_CLEAR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GLAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid level accumulate check failed");

// next-cycle implication, disabled while reset is low
`define GLAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid level accumulate check failed");

`endif

// File: rtl/glac_pkg.sv
// shared types and constants of the grid level accumulator
// no dependencies
`timescale 1ns / 1ps

package glac_pkg;

  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned WORLD_W    = 20;
  localparam int unsigned TPU_W      = 24;
  localparam int unsigned GRID_W     = 7;
  localparam int unsigned DIM_W      = 9;                 // holds a dimension up to 256
  localparam int unsigned PROD_W     = WORLD_W + TPU_W;
  localparam int unsigned TILE_W     = PROD_W - TPU_W;    // integer part of world * scale
  localparam int unsigned SQ_W       = 2 * TILE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_CAP  = 8'd200;

  localparam logic [LEVEL_W-1:0] RATE_RST   = 17'd655;
  localparam logic [GRID_W-1:0]  WIDTH_RST  = 7'd64;
  localparam logic [GRID_W-1:0]  HEIGHT_RST = 7'd64;
  localparam logic [TPU_W-1:0]   TPU_RST    = 24'd65536;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_PATROL = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_TPU    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SC_X = 2'd0,
    SC_Y = 2'd1,
    SC_R = 2'd2
  } scale_step_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCALE,
    ST_SQUARE,
    ST_SWEEP,
    ST_DRAIN,
    ST_QADDR,
    ST_QREAD,
    ST_QDATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [WORLD_W-1:0] pos_x;
    logic [WORLD_W-1:0] pos_y;
    logic [WORLD_W-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [ALPHA_W-1:0] alpha;
    logic               out_of_range;
    logic               done_res;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rate_per_tick;
    logic [GRID_W-1:0]  grid_width;
    logic [GRID_W-1:0]  grid_height;
    logic [TPU_W-1:0]   tiles_per_unit;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

endpackage

// File: rtl/glac_tile_ram.sv
// tile level storage: one write port, one read port, registered read data
// uses glac_pkg
`timescale 1ns / 1ps

module glac_tile_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [glac_pkg::LEVEL_W-1:0]  rd_data_r,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [glac_pkg::LEVEL_W-1:0]  wr_data
);

  logic [glac_pkg::LEVEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/glac_engine.sv
// sequencer and datapath: clearing pass, tick and patrol sweeps, tile query
// uses glac_pkg; drives the tile ram ports
`timescale 1ns / 1ps

module glac_engine #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned DEPTH      = 4096,
  parameter int unsigned AW         = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  glac_pkg::cfg_t                cfg,
  input  logic                          item_take,
  input  glac_pkg::in_item_t            item,
  input  logic                          res_ready,
  output glac_pkg::eng_stat_t           stat,
  output glac_pkg::out_item_t           res,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  logic [glac_pkg::LEVEL_W-1:0]  rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [glac_pkg::LEVEL_W-1:0]  wr_data
);

  localparam int unsigned DIM_W  = glac_pkg::DIM_W;
  localparam int unsigned TILE_W = glac_pkg::TILE_W;
  localparam int unsigned SQ_W   = glac_pkg::SQ_W;
  localparam int unsigned PROD_W = glac_pkg::PROD_W;
  localparam int unsigned TPU_W  = glac_pkg::TPU_W;
  localparam int unsigned LVL_W  = glac_pkg::LEVEL_W;
  localparam int unsigned LIN_W  = 2 * DIM_W;
  localparam logic [DIM_W-1:0] MAX_W_D   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D   = DIM_W'(MAX_HEIGHT);
  localparam logic [AW-1:0]    ROW_STEP  = AW'(MAX_WIDTH);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

  glac_pkg::state_t      state_r, state_nxt;
  glac_pkg::scale_step_t step_r;
  glac_pkg::in_item_t    item_r;
  glac_pkg::out_item_t   res_r;

  logic [AW-1:0]     clr_addr_r;
  logic [DIM_W-1:0]  x_r, y_r;
  logic [AW-1:0]     row_base_r;
  logic [TILE_W-1:0] cx_r, cy_r, rt_r;
  logic [SQ_W-1:0]   r2_r;
  logic              p1_valid_r;
  logic [AW-1:0]     p1_addr_r;
  logic [SQ_W-1:0]   p1_dx2_r, p1_dy2_r;
  logic              q_oor_r;
  logic [AW-1:0]     q_addr_r;

  logic [DIM_W-1:0]            used_w, used_h;
  logic                        grid_empty;
  logic                        is_tick, is_patrol;
  logic [glac_pkg::WORLD_W-1:0] mul_src;
  logic [PROD_W-1:0]           prod;
  logic [TILE_W-1:0]           tile_val;
  logic                        scale_last;
  logic [AW-1:0]               sweep_addr;
  logic                        x_last, y_last;
  logic [TILE_W-1:0]           xe, ye, dx, dy;
  logic [SQ_W-1:0]             dx2, dy2;
  logic [LVL_W:0]              sum;
  logic [LVL_W-1:0]            sat;
  logic                        inside_disc;
  logic [LIN_W-1:0]            q_lin;
  logic [LVL_W+7:0]            a_prod;
  logic [8:0]                  a9;
  glac_pkg::out_item_t         q_res;
  glac_pkg::out_item_t         res_idle;

  // grid in use, clipped to the storage size
  assign used_w = (DIM_W'(cfg.grid_width) > MAX_W_D) ? MAX_W_D : DIM_W'(cfg.grid_width);
  assign used_h = (DIM_W'(cfg.grid_height) > MAX_H_D) ? MAX_H_D : DIM_W'(cfg.grid_height);
  assign grid_empty = (used_w == '0) || (used_h == '0);

  assign is_tick   = (item_r.action == glac_pkg::ACT_TICK);
  assign is_patrol = (item_r.action == glac_pkg::ACT_PATROL);

  // shared world-to-tile scaler, one coordinate per cycle
  always_comb begin
    unique case (step_r)
      glac_pkg::SC_X: mul_src = item_r.pos_x;
      glac_pkg::SC_Y: mul_src = item_r.pos_y;
      default:        mul_src = item_r.radius;
    endcase
  end
  assign prod       = PROD_W'(mul_src) * PROD_W'(cfg.tiles_per_unit);
  assign tile_val   = prod[PROD_W-1:TPU_W];
  assign scale_last = (step_r == glac_pkg::SC_R) || (step_r == glac_pkg::SC_Y && !is_patrol);

  // sweep front end: address and squared distances
  assign sweep_addr = row_base_r + AW'(x_r);
  assign x_last     = ((x_r + DIM_W'(1)) == used_w);
  assign y_last     = ((y_r + DIM_W'(1)) == used_h);
  assign xe         = TILE_W'(x_r);
  assign ye         = TILE_W'(y_r);
  assign dx         = (cx_r > xe) ? (cx_r - xe) : (xe - cx_r);
  assign dy         = (cy_r > ye) ? (cy_r - ye) : (ye - cy_r);
  assign dx2        = SQ_W'(dx) * SQ_W'(dx);
  assign dy2        = SQ_W'(dy) * SQ_W'(dy);

  // sweep back end: saturating add or disc test
  assign sum         = {1'b0, rd_data} + {1'b0, cfg.rate_per_tick};
  assign sat         = (sum > {1'b0, glac_pkg::FULL_LEVEL}) ? glac_pkg::FULL_LEVEL
                                                             : sum[LVL_W-1:0];
  assign inside_disc = ({1'b0, p1_dx2_r} + {1'b0, p1_dy2_r}) < {1'b0, r2_r};

  // query address and alpha
  assign q_lin  = LIN_W'(cy_r[DIM_W-1:0]) * LIN_W'(MAX_WIDTH) + LIN_W'(cx_r[DIM_W-1:0]);
  assign a_prod = {rd_data, 8'b0} - {8'b0, rd_data};
  assign a9     = a_prod[LVL_W+7:16];

  always_comb begin
    res_idle              = '0;
    res_idle.done_res     = 1'b1;
    q_res                 = res_idle;
    q_res.out_of_range    = q_oor_r;
    if (!q_oor_r) begin
      q_res.level = rd_data;
      q_res.alpha = (a9 > {1'b0, glac_pkg::ALPHA_CAP}) ? glac_pkg::ALPHA_CAP : a9[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glac_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stat.idle      = 1'b0;
    stat.res_valid = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = sweep_addr;
    wr_en         = p1_valid_r && (is_tick || (is_patrol && inside_disc));
    wr_addr       = p1_addr_r;
    wr_data       = is_tick ? sat : '0;
    unique case (state_r)
      glac_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = glac_pkg::ST_IDLE;
        end
      end
      glac_pkg::ST_IDLE: begin
        stat.idle = 1'b1;
        if (item_take) begin
          unique case (item.action)
            glac_pkg::ACT_TICK:   state_nxt = grid_empty ? glac_pkg::ST_DONE
                                                         : glac_pkg::ST_SWEEP;
            glac_pkg::ACT_PATROL: state_nxt = glac_pkg::ST_SCALE;
            glac_pkg::ACT_QUERY:  state_nxt = glac_pkg::ST_SCALE;
            default:              state_nxt = glac_pkg::ST_DONE;
          endcase
        end
      end
      glac_pkg::ST_SCALE: begin
        if (scale_last) begin
          state_nxt = is_patrol ? glac_pkg::ST_SQUARE : glac_pkg::ST_QADDR;
        end
      end
      glac_pkg::ST_SQUARE: begin
        state_nxt = grid_empty ? glac_pkg::ST_DONE : glac_pkg::ST_SWEEP;
      end
      glac_pkg::ST_SWEEP: begin
        rd_en = is_tick;
        if (x_last && y_last) begin
          state_nxt = glac_pkg::ST_DRAIN;
        end
      end
      glac_pkg::ST_DRAIN: begin
        state_nxt = glac_pkg::ST_DONE;
      end
      glac_pkg::ST_QADDR: begin
        state_nxt = glac_pkg::ST_QREAD;
      end
      glac_pkg::ST_QREAD: begin
        rd_en     = !q_oor_r;
        rd_addr   = q_addr_r;
        state_nxt = glac_pkg::ST_QDATA;
      end
      glac_pkg::ST_QDATA: begin
        state_nxt = glac_pkg::ST_DONE;
      end
      glac_pkg::ST_DONE: begin
        stat.res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = glac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = glac_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      step_r     <= glac_pkg::SC_X;
      x_r        <= '0;
      y_r        <= '0;
      row_base_r <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= (state_r == glac_pkg::ST_SWEEP);
      if (state_r == glac_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == glac_pkg::ST_IDLE) begin
        step_r     <= glac_pkg::SC_X;
        x_r        <= '0;
        y_r        <= '0;
        row_base_r <= '0;
      end else if (state_r == glac_pkg::ST_SCALE) begin
        unique case (step_r)
          glac_pkg::SC_X: step_r <= glac_pkg::SC_Y;
          glac_pkg::SC_Y: step_r <= glac_pkg::SC_R;
          default:        step_r <= glac_pkg::SC_R;
        endcase
      end else if (state_r == glac_pkg::ST_SWEEP) begin
        if (x_last) begin
          x_r        <= '0;
          y_r        <= y_r + DIM_W'(1);
          row_base_r <= row_base_r + ROW_STEP;
        end else begin
          x_r <= x_r + DIM_W'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p1_addr_r <= sweep_addr;
    p1_dx2_r  <= dx2;
    p1_dy2_r  <= dy2;
    if (item_take && state_r == glac_pkg::ST_IDLE) begin
      item_r <= item;
      res_r  <= res_idle;
    end
    if (state_r == glac_pkg::ST_SCALE) begin
      unique case (step_r)
        glac_pkg::SC_X: cx_r <= tile_val;
        glac_pkg::SC_Y: cy_r <= tile_val;
        default:        rt_r <= tile_val;
      endcase
    end
    if (state_r == glac_pkg::ST_SQUARE) begin
      r2_r <= SQ_W'(rt_r) * SQ_W'(rt_r);
    end
    if (state_r == glac_pkg::ST_QADDR) begin
      q_oor_r  <= (cx_r >= TILE_W'(used_w)) || (cy_r >= TILE_W'(used_h));
      q_addr_r <= AW'(q_lin);
    end
    if (state_r == glac_pkg::ST_QDATA) begin
      res_r <= q_res;
    end
  end

endmodule

// File: rtl/grid_level_accumulate_clear.sv
// Grid level accumulator. A grid of up to MAX_WIDTH x MAX_HEIGHT tiles keeps a
// 17-bit level per tile (65536 is full) in one single-port-read, single-port-write
// memory. After reset a clearing pass writes zero to every entry (MAX_WIDTH *
// MAX_HEIGHT, 4096 at the default size), one entry per cycle; in_stall stays
// high during it while configuration writes are taken as ever. Every transaction
// returns exactly one result. A tick sweeps the grid in use (each size clipped to
// its maximum) with one read-modify-write per cycle; a patrol scales center and
// radius through one shared multiplier, squares the radius and sweeps the same
// way; a query scales the center, forms the tile address and reads the tile when
// it lies on the grid. An unused action or a tick on an empty grid goes straight
// to its result; a patrol on an empty grid scales and squares but does not sweep.
// The tile memory port, one tile per cycle, sets the sweep length. Items are
// worked one at a time; a finished result waits in an output register so the
// next transaction can be taken while it is stalled.
// depends on glac_pkg, glac_tile_ram, glac_engine
`timescale 1ns / 1ps

module grid_level_accumulate_clear #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_stall,
  input  glac_pkg::in_item_t                in_data,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_stall,
  output glac_pkg::out_item_t               out_data,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [glac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [glac_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  glac_pkg::cfg_t      cfg_r;
  glac_pkg::eng_stat_t stat;
  glac_pkg::out_item_t res;
  glac_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  logic                slot_free;
  logic                item_take;

  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [glac_pkg::LEVEL_W-1:0]  rd_data, wr_data;

  // config registers are always writable; writes must only come while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_per_tick  <= glac_pkg::RATE_RST;
      cfg_r.grid_width     <= glac_pkg::WIDTH_RST;
      cfg_r.grid_height    <= glac_pkg::HEIGHT_RST;
      cfg_r.tiles_per_unit <= glac_pkg::TPU_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        glac_pkg::CFG_RATE:   cfg_r.rate_per_tick  <= cfg_data[glac_pkg::LEVEL_W-1:0];
        glac_pkg::CFG_WIDTH:  cfg_r.grid_width     <= cfg_data[glac_pkg::GRID_W-1:0];
        glac_pkg::CFG_HEIGHT: cfg_r.grid_height    <= cfg_data[glac_pkg::GRID_W-1:0];
        glac_pkg::CFG_TPU:    cfg_r.tiles_per_unit <= cfg_data[glac_pkg::TPU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // new transactions only enter an idle engine
  assign in_stall  = !stat.idle;
  assign item_take = in_valid && !in_stall;

  // output register: loads when empty or being drained this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && slot_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  glac_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_take (item_take),
    .item      (in_data),
    .res_ready (slot_free),
    .stat      (stat),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  glac_tile_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_tile_ram (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

// File: rtl/glac_checker.sv
// port-level checks of the grid level accumulator, bound to the top level
// depends on glac_pkg and grid_level_accumulate_clear_defines.svh
`timescale 1ns / 1ps
`include "grid_level_accumulate_clear_defines.svh"

module glac_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input glac_pkg::out_item_t out_data
);

  logic level_ok;
  logic oor_clean;

  assign level_ok  = (out_data.level <= glac_pkg::FULL_LEVEL) &&
                     (out_data.alpha <= glac_pkg::ALPHA_CAP);
  assign oor_clean = (out_data.level == '0) && (out_data.alpha == '0);

  // a stalled result holds
  `GLAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // the engine is busy right after it takes a transaction
  `GLAC_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

  `GLAC_ASSERT_IMP(a_done_set, clk, rst_n, out_valid, out_data.done_res)

  `GLAC_ASSERT_IMP(a_value_range, clk, rst_n, out_valid, level_ok)

  // off-grid queries carry no level
  `GLAC_ASSERT_IMP(a_oor_zero, clk, rst_n, out_valid && out_data.out_of_range, oor_clean)

endmodule

bind grid_level_accumulate_clear glac_checker u_glac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
